[rtl/core/srt_pkg.sv]
// package for the sorted record table: widths, codes, state type
`timescale 1ns / 1ps
package srt_pkg;
    localparam int CAPACITY_DEF   = 16;
    localparam int NAME_BYTES_DEF = 8;
    localparam int TYPE_BYTES_DEF = 8;
    localparam int KEY_W          = 64;
    localparam int QTY_W          = 16;
    localparam int PRIO_W         = 3;
    localparam int CMP_W          = 7;

    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_SORT   = 3'd2;
    localparam logic [2:0] REQ_SEARCH = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BAD_PRIO  = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    localparam logic [1:0] SEL_NAME = 2'd0;
    localparam logic [1:0] SEL_TYPE = 2'd1;
    localparam logic [1:0] SEL_PRIO = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_RM_SCAN, S_RM_SHIFT, S_SO_LOAD, S_SO_CMP,
        S_SO_PLACE, S_SE_RD, S_SE_CMP, S_RD, S_DONE
    } t_state;

    function automatic logic [KEY_W-1:0] cut_key(input logic [KEY_W-1:0] k,
                                                 input int bytes);
        logic [KEY_W-1:0] m;
        m = '1 << (8 * (8 - bytes));
        return k & m;
    endfunction
endpackage

[rtl/core/srt_mem.sv]
// record memory: one write port, one registered read port
`timescale 1ns / 1ps
module srt_mem
    import srt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W = $clog2(CAPACITY)
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [IDX_W-1:0]                i_waddr,
    input  logic [KEY_W*2+QTY_W+PRIO_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]                i_raddr,
    output logic [KEY_W*2+QTY_W+PRIO_W-1:0] o_rdata
);
    logic [KEY_W*2+QTY_W+PRIO_W-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/sorted_record_table.sv]
// sorted record table top level: request sequencer around one record memory
// usage:
//   one request beat on the input channel (i_valid/o_stall), one result beat
//   on the output channel (o_valid/i_stall) per request.
//   requests: append, remove by name, stable insertion sort, binary search by
//   name, read by index. the table lives in a single-port-read memory and a
//   shared 64-bit comparator steps through it under a small sequencer.
//   each request passes a dispatch state, then remove scans the table and
//   shifts the later entries down, read fetches one record, search reads and
//   compares one probe at a time, and sort loads each element after the first,
//   compares it against the entries before it and places it. all of these
//   steps go through the single memory read port.
//   one request is in flight at a time: o_stall is high from acceptance until
//   the result beat is taken; the next request beat can be taken in the cycle
//   after the result beat.
//   reset clears the entry count and the last sort count; memory contents are
//   not cleared, entries beyond the count are never read.
//   a stalled result holds steady until i_stall drops.
`timescale 1ns / 1ps
module sorted_record_table
    import srt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF,
    parameter int TYPE_BYTES = TYPE_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_req_type,
    input  logic [KEY_W-1:0]         i_name_key,
    input  logic [KEY_W-1:0]         i_type_key,
    input  logic signed [QTY_W-1:0]  i_item_quantity,
    input  logic [3:0]               i_item_priority,
    input  logic [1:0]               i_sort_key_select,
    input  logic [3:0]               i_read_index,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [2:0]               o_status,
    output logic [3:0]               o_found_index,
    output logic [CMP_W-1:0]         o_compare_count,
    output logic [4:0]               o_entry_total,
    output logic [KEY_W-1:0]         o_out_name,
    output logic [KEY_W-1:0]         o_out_type,
    output logic signed [QTY_W-1:0]  o_out_quantity,
    output logic [PRIO_W-1:0]        o_out_priority
);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int REC_W = KEY_W * 2 + QTY_W + PRIO_W;
    localparam int SRC_W = IDX_W + 1;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CMP_W-1:0] r_cmp, n_cmp;
    logic [CMP_W-1:0] r_cmp_run, n_cmp_run;

    // captured request
    logic [2:0]       r_req;
    logic [KEY_W-1:0] r_name, r_type;
    logic [QTY_W-1:0] r_qty;
    logic [3:0]       r_prio;
    logic [1:0]       r_sel;
    logic [3:0]       r_ridx;

    // walk registers
    logic [SRC_W-1:0] r_i, n_i;   // outer index / scan index
    logic [SRC_W-1:0] r_j, n_j;   // insertion hole
    logic [SRC_W-1:0] r_lo, n_lo, r_hi, n_hi;  // search bounds, signed-ish via +1 offset
    logic [REC_W-1:0] r_hold, n_hold;

    // result registers
    logic [2:0]       r_status, n_status;
    logic [IDX_W-1:0] r_fidx, n_fidx;
    logic             r_has_rec, n_has_rec;
    logic [REC_W-1:0] r_orec, n_orec;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [REC_W-1:0] mem_wdata, mem_rdata;
    logic [SRC_W-1:0] mid;

    srt_mem #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // record field views
    logic [KEY_W-1:0] rd_name, rd_type;
    logic [PRIO_W-1:0] rd_prio;
    assign rd_name = mem_rdata[REC_W-1 -: KEY_W];
    assign rd_type = mem_rdata[REC_W-KEY_W-1 -: KEY_W];
    assign rd_prio = mem_rdata[PRIO_W-1:0];

    // shared comparator: selected key of the read record against a held key
    logic [KEY_W-1:0] cmp_a, cmp_b;
    logic             cmp_gt, cmp_eq;
    always_comb begin
        cmp_a = rd_name;
        cmp_b = r_name;
        case (r_state)
            S_SO_CMP: begin
                case (r_sel)
                    SEL_NAME: begin cmp_a = rd_name; cmp_b = r_hold[REC_W-1 -: KEY_W]; end
                    SEL_TYPE: begin
                        cmp_a = rd_type;
                        cmp_b = r_hold[REC_W-KEY_W-1 -: KEY_W];
                    end
                    default: begin
                        cmp_a = {{(KEY_W-PRIO_W){1'b0}}, rd_prio};
                        cmp_b = {{(KEY_W-PRIO_W){1'b0}}, r_hold[PRIO_W-1:0]};
                    end
                endcase
            end
            default: begin
                cmp_a = rd_name;
                cmp_b = r_name;
            end
        endcase
    end
    assign cmp_gt = cmp_a > cmp_b;
    assign cmp_eq = cmp_a == cmp_b;

    assign mid = SRC_W'((({1'b0, r_lo} + {1'b0, r_hi}) >> 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp     <= n_cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_req  <= i_req_type;
            r_name <= cut_key(i_name_key, NAME_BYTES);
            r_type <= cut_key(i_type_key, TYPE_BYTES);
            r_qty  <= i_item_quantity;
            r_prio <= i_item_priority;
            r_sel  <= i_sort_key_select;
            r_ridx <= i_read_index;
        end
        r_cmp_run <= n_cmp_run;
        r_i       <= n_i;
        r_j       <= n_j;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_hold    <= n_hold;
        r_status  <= n_status;
        r_fidx    <= n_fidx;
        r_has_rec <= n_has_rec;
        r_orec    <= n_orec;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cmp     = r_cmp;
        n_cmp_run = r_cmp_run;
        n_i       = r_i;
        n_j       = r_j;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_hold    = r_hold;
        n_status  = r_status;
        n_fidx    = r_fidx;
        n_has_rec = r_has_rec;
        n_orec    = r_orec;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_hold;
        mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_status  = ST_OK;
                n_has_rec = 1'b0;
                n_fidx    = '0;
                n_state   = S_DONE;
                case (r_req)
                    REQ_APPEND: begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else if (r_prio < 4'd1 || r_prio > 4'd5) begin
                            n_status = ST_BAD_PRIO;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[IDX_W-1:0];
                            mem_wdata = {r_name, r_type, r_qty, r_prio[PRIO_W-1:0]};
                            n_count   = r_count + 1'b1;
                        end
                    end
                    REQ_REMOVE: begin
                        n_status  = ST_NOT_FOUND;
                        n_i       = '0;
                        mem_raddr = '0;
                        if (r_count != '0) begin
                            n_state = S_RM_SCAN;
                        end
                    end
                    REQ_SORT: begin
                        if (r_count != '0 && r_sel != 2'd3) begin
                            n_cmp_run = '0;
                            n_i       = SRC_W'(1);
                            if (r_count > CNT_W'(1)) begin
                                mem_raddr = IDX_W'(1);
                                n_state   = S_SO_LOAD;
                            end else begin
                                n_cmp = '0;
                            end
                        end
                    end
                    REQ_SEARCH: begin
                        n_status = ST_NOT_FOUND;
                        n_lo     = SRC_W'(1);
                        n_hi     = SRC_W'(r_count);
                        if (r_count != '0) begin
                            n_state = S_SE_RD;
                        end
                    end
                    REQ_READ: begin
                        if ({1'b0, r_ridx} < 5'(r_count)) begin
                            mem_raddr = r_ridx[IDX_W-1:0];
                            n_fidx    = r_ridx[IDX_W-1:0];
                            n_state   = S_RD;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            // remove: data for r_i is on the read port
            S_RM_SCAN: begin
                if (cmp_eq) begin
                    n_status = ST_OK;
                    if (r_i + 1'b1 < SRC_W'(r_count)) begin
                        mem_raddr = IDX_W'(r_i + 1'b1);
                        n_state   = S_RM_SHIFT;
                    end else begin
                        n_count = r_count - 1'b1;
                        n_state = S_DONE;
                    end
                end else if (r_i + 1'b1 < SRC_W'(r_count)) begin
                    n_i       = r_i + 1'b1;
                    mem_raddr = IDX_W'(r_i + 1'b1);
                end else begin
                    n_state = S_DONE;
                end
            end
            // shift: record i+1 is on the read port, write to i
            S_RM_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[IDX_W-1:0];
                mem_wdata = mem_rdata;
                n_i       = r_i + 1'b1;
                if (r_i + SRC_W'(2) < SRC_W'(r_count)) begin
                    mem_raddr = IDX_W'(r_i + SRC_W'(2));
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            // sort: record i is on the read port, hold it
            S_SO_LOAD: begin
                n_hold    = mem_rdata;
                n_j       = r_i;
                mem_raddr = IDX_W'(r_i - 1'b1);
                n_state   = S_SO_CMP;
            end
            // record j-1 is on the read port
            S_SO_CMP: begin
                if (r_cmp_run != '1) begin
                    n_cmp_run = r_cmp_run + 1'b1;
                end
                if (cmp_gt) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_j[IDX_W-1:0];
                    mem_wdata = mem_rdata;
                    n_j       = r_j - 1'b1;
                    if (r_j == SRC_W'(1)) begin
                        n_state = S_SO_PLACE;
                    end else begin
                        mem_raddr = IDX_W'(r_j - SRC_W'(2));
                    end
                end else begin
                    n_state = S_SO_PLACE;
                end
            end
            S_SO_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = r_j[IDX_W-1:0];
                mem_wdata = r_hold;
                if (r_i + 1'b1 < SRC_W'(r_count)) begin
                    n_i       = r_i + 1'b1;
                    mem_raddr = IDX_W'(r_i + 1'b1);
                    n_state   = S_SO_LOAD;
                end else begin
                    n_cmp   = r_cmp_run;
                    n_state = S_DONE;
                end
            end
            // search bounds are held one above the real index
            S_SE_RD: begin
                if (r_lo <= r_hi) begin
                    mem_raddr = IDX_W'(mid - 1'b1);
                    n_i       = mid;
                    n_state   = S_SE_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SE_CMP: begin
                if (cmp_eq) begin
                    n_status  = ST_OK;
                    n_has_rec = 1'b1;
                    n_orec    = mem_rdata;
                    n_fidx    = IDX_W'(r_i - 1'b1);
                    n_state   = S_DONE;
                end else if (!cmp_gt) begin
                    n_lo    = r_i + 1'b1;
                    n_state = S_SE_RD;
                end else begin
                    n_hi    = r_i - 1'b1;
                    n_state = S_SE_RD;
                end
            end
            S_RD: begin
                n_has_rec = 1'b1;
                n_orec    = mem_rdata;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_DONE);
    assign o_status        = r_status;
    assign o_found_index   = r_has_rec ? 4'(r_fidx) : 4'd0;
    assign o_compare_count = r_cmp;
    assign o_entry_total   = 5'(r_count);
    assign o_out_name      = r_has_rec ? r_orec[REC_W-1 -: KEY_W] : '0;
    assign o_out_type      = r_has_rec ? r_orec[REC_W-KEY_W-1 -: KEY_W] : '0;
    assign o_out_quantity  = r_has_rec ? r_orec[PRIO_W +: QTY_W] : '0;
    assign o_out_priority  = r_has_rec ? r_orec[PRIO_W-1:0] : '0;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_count))
        else $error("count changed while idle");
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_status))
        else $error("result changed under stall");
    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_has_rec) |-> (o_status == ST_OK))
        else $error("record returned with error status");
`endif
endmodule
